FILE: hw/rtl/line_rasterizer_pixel_writer_defines.svh
// Assertion helpers for the line rasterizer
`ifndef LINE_RASTERIZER_PIXEL_WRITER_DEFINES_SVH
`define LINE_RASTERIZER_PIXEL_WRITER_DEFINES_SVH

// same-cycle implication
`define LRPW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRPW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lrpw_pkg.sv
package lrpw_pkg;

    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 72;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int BPP_W        = 3;
    localparam int PITCH_W      = 16;
    localparam int LIMIT_W      = 12;
    localparam int FIELD_W      = 16;
    localparam int COLOR_W      = 32;
    localparam int ADDR_FIELD_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_BPP        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_X      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_Y      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [BPP_W-1:0]   BPP_ONE   = 3'd1;
    localparam logic [BPP_W-1:0]   BPP_TWO   = 3'd2;
    localparam logic [BPP_W-1:0]   BPP_THREE = 3'd3;
    localparam logic [BPP_W-1:0]   BPP_FOUR  = 3'd4;
    localparam logic [BPP_W-1:0]   BPP_NONE  = 3'd0;

    localparam logic [7:0] BYTE_MASK = 8'hff;

    localparam logic [BPP_W-1:0]   RST_BPP       = 3'd4;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH = 16'd2560;
    localparam logic [LIMIT_W-1:0] RST_MAX_X     = 12'd639;
    localparam logic [LIMIT_W-1:0] RST_MAX_Y     = 12'd479;

    typedef struct packed {
        logic [COLOR_W-1:0] line_color;
        logic [FIELD_W-1:0] end_y;
        logic [FIELD_W-1:0] end_x;
        logic [FIELD_W-1:0] start_y;
        logic [FIELD_W-1:0] start_x;
    } in_word_t;

    typedef struct packed {
        logic [4:0]              pad;
        logic [BPP_W-1:0]        byte_count;
        logic [COLOR_W-1:0]      pixel_data;
        logic [ADDR_FIELD_W-1:0] pixel_address;
    } out_word_t;

endpackage

FILE: hw/rtl/line_rasterizer_pixel_writer.sv
// An accepted word is held in the input register; its pixel write enters the output register
// once that register is free (empty or m_tready high).
// Throughput: one word per cycle while m_tready is high, set by the single combinational
// step between the input and output registers; starts and idle steps emit nothing.
// Reset: synchronous on aresetn low; no line active, no word held or output, config registers at their defaults.
`include "line_rasterizer_pixel_writer_defines.svh"

module line_rasterizer_pixel_writer #(
    parameter int COORD_WIDTH = 12,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48], line_color[95:64]
    input  logic [95:0] s_tdata,
    // operation[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_address[31:0], pixel_data[63:32], byte_count[66:64], zero pad[71:67]
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    localparam int CW     = COORD_WIDTH;
    localparam int ERR_W  = COORD_WIDTH + 2;
    localparam int CNT_W  = COORD_WIDTH + 1;
    localparam int YP_W   = COORD_WIDTH + lrpw_pkg::PITCH_W;
    localparam int XP_W   = COORD_WIDTH + lrpw_pkg::BPP_W;
    localparam int SUM_W  = YP_W + 1;
    localparam int AF_W   = lrpw_pkg::ADDR_FIELD_W;
    localparam int COL_W  = lrpw_pkg::COLOR_W;

    // configuration
    logic [lrpw_pkg::BPP_W-1:0]   bpp_reg;
    logic [lrpw_pkg::PITCH_W-1:0] pitch_reg;
    logic [lrpw_pkg::LIMIT_W-1:0] max_x_reg;
    logic [lrpw_pkg::LIMIT_W-1:0] max_y_reg;
    logic                         big_endian_reg;

    // input register
    logic                 in_valid_reg;
    lrpw_pkg::in_word_t   in_word_reg;
    logic                 in_op_reg;

    // line state
    logic                  line_active_reg, line_active_next;
    logic [ADDR_WIDTH-1:0] offset_reg, offset_next;
    logic [ERR_W-1:0]      err_reg, err_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [CW-1:0]         major_reg, major_next;
    logic [CW-1:0]         minor_reg, minor_next;
    logic                  x_major_reg, x_major_next;
    logic                  x_neg_reg, x_neg_next;
    logic                  y_neg_reg, y_neg_next;
    logic [COL_W-1:0]      color_reg, color_next;

    // output register
    logic                 m_tvalid_reg;
    lrpw_pkg::out_word_t  out_word_reg, out_word_next;
    logic                 last_reg, last_next;

    logic                          out_free, emit, adv;
    logic [lrpw_pkg::BPP_W-1:0]    bpp_eff;
    logic [CW-1:0]                 x1, y1, x2, y2, dx, dy;
    logic                          xn, yn, xm;
    logic [YP_W-1:0]               yprod;
    logic [XP_W-1:0]               xprod;
    logic [SUM_W-1:0]              start_sum;
    logic [ADDR_WIDTH-1:0]         off1;
    logic [ERR_W-1:0]              err_sum;
    logic                          is_last;

    function automatic logic [CW-1:0] clamp_coord(input logic [15:0] v,
                                                  input logic [lrpw_pkg::LIMIT_W-1:0] limit);
        logic [15:0] lim16;
        lim16 = 16'(limit);
        if (v[15]) begin
            return '0;
        end else if (v > lim16) begin
            return lim16[CW-1:0];
        end else begin
            return v[CW-1:0];
        end
    endfunction

    function automatic logic [ADDR_WIDTH-1:0] step_by(input logic [ADDR_WIDTH-1:0] off,
                                                      input logic [lrpw_pkg::PITCH_W-1:0] amt,
                                                      input logic neg);
        logic [ADDR_WIDTH-1:0] a;
        a = ADDR_WIDTH'(amt);
        return neg ? off - a : off + a;
    endfunction

    function automatic logic [COL_W-1:0] pack_color(input logic [COL_W-1:0] c,
                                                    input logic [lrpw_pkg::BPP_W-1:0] bpp,
                                                    input logic be);
        logic [COL_W-1:0] r;
        case (bpp)
            lrpw_pkg::BPP_ONE:   r = c & COL_W'(lrpw_pkg::BYTE_MASK);
            lrpw_pkg::BPP_TWO:   r = {16'h0000, c[15:0]};
            lrpw_pkg::BPP_THREE: r = be ? {8'h00, c[7:0], c[15:8], c[23:16]}
                                        : {8'h00, c[23:0]};
            default:             r = c;
        endcase
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = in_valid_reg && (in_op_reg == lrpw_pkg::OP_STEP) && line_active_reg;
    assign adv       = in_valid_reg && (!emit || out_free);
    assign s_tready  = !in_valid_reg || adv;

    always_comb begin
        case (bpp_reg)
            lrpw_pkg::BPP_NONE:  bpp_eff = lrpw_pkg::BPP_ONE;
            lrpw_pkg::BPP_ONE:   bpp_eff = lrpw_pkg::BPP_ONE;
            lrpw_pkg::BPP_TWO:   bpp_eff = lrpw_pkg::BPP_TWO;
            lrpw_pkg::BPP_THREE: bpp_eff = lrpw_pkg::BPP_THREE;
            default:             bpp_eff = lrpw_pkg::BPP_FOUR;
        endcase
    end

    // start word set-up
    always_comb begin
        x1 = clamp_coord(in_word_reg.start_x, max_x_reg);
        y1 = clamp_coord(in_word_reg.start_y, max_y_reg);
        x2 = clamp_coord(in_word_reg.end_x, max_x_reg);
        y2 = clamp_coord(in_word_reg.end_y, max_y_reg);
        xn = x2 < x1;
        yn = y2 < y1;
        dx = xn ? x1 - x2 : x2 - x1;
        dy = yn ? y1 - y2 : y2 - y1;
        xm = dx > dy;
        yprod = YP_W'(y1) * YP_W'(pitch_reg);
        xprod = XP_W'(x1) * XP_W'(bpp_eff);
        start_sum = SUM_W'(yprod) + SUM_W'(xprod);
    end

    always_comb begin
        line_active_next = line_active_reg;
        offset_next      = offset_reg;
        err_next         = err_reg;
        left_next        = left_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        x_major_next     = x_major_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        color_next       = color_reg;
        is_last          = left_reg <= CNT_W'(1);
        off1             = x_major_reg ? step_by(offset_reg, 16'(bpp_eff), x_neg_reg)
                                       : step_by(offset_reg, pitch_reg, y_neg_reg);
        err_sum          = err_reg + ERR_W'(minor_reg);

        out_word_next.pad           = '0;
        out_word_next.byte_count    = bpp_eff;
        out_word_next.pixel_data    = pack_color(color_reg, bpp_eff, big_endian_reg);
        out_word_next.pixel_address = AF_W'(offset_reg);
        last_next                   = is_last;

        if (in_op_reg == lrpw_pkg::OP_START) begin
            x_neg_next       = xn;
            y_neg_next       = yn;
            x_major_next     = xm;
            major_next       = xm ? dx : dy;
            minor_next       = xm ? dy : dx;
            offset_next      = ADDR_WIDTH'(start_sum);
            err_next         = '0;
            left_next        = CNT_W'(xm ? dx : dy) + CNT_W'(1);
            color_next       = in_word_reg.line_color;
            line_active_next = 1'b1;
        end else if (line_active_reg) begin
            offset_next = off1;
            err_next    = err_sum;
            if (err_sum > ERR_W'(major_reg)) begin
                err_next    = err_sum - ERR_W'(major_reg);
                offset_next = x_major_reg ? step_by(off1, pitch_reg, y_neg_reg)
                                          : step_by(off1, 16'(bpp_eff), x_neg_reg);
            end
            if (is_last) begin
                left_next        = '0;
                line_active_next = 1'b0;
            end else begin
                left_next = left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg        <= lrpw_pkg::RST_BPP;
            pitch_reg      <= lrpw_pkg::RST_ROW_PITCH;
            max_x_reg      <= lrpw_pkg::RST_MAX_X;
            max_y_reg      <= lrpw_pkg::RST_MAX_Y;
            big_endian_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                lrpw_pkg::REG_BPP:        bpp_reg        <= cfg_data[lrpw_pkg::BPP_W-1:0];
                lrpw_pkg::REG_ROW_PITCH:  pitch_reg      <= cfg_data;
                lrpw_pkg::REG_MAX_X:      max_x_reg      <= cfg_data[lrpw_pkg::LIMIT_W-1:0];
                lrpw_pkg::REG_MAX_Y:      max_y_reg      <= cfg_data[lrpw_pkg::LIMIT_W-1:0];
                lrpw_pkg::REG_BIG_ENDIAN: big_endian_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            line_active_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                line_active_reg <= line_active_next;
            end
            if (emit && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= lrpw_pkg::in_word_t'(s_tdata);
            in_op_reg   <= s_tuser[0];
        end
        if (adv) begin
            offset_reg  <= offset_next;
            err_reg     <= err_next;
            left_reg    <= left_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            x_major_reg <= x_major_next;
            x_neg_reg   <= x_neg_next;
            y_neg_reg   <= y_neg_next;
            color_reg   <= color_next;
        end
        if (emit && out_free) begin
            out_word_reg <= out_word_next;
            last_reg     <= last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = last_reg;

    `LRPW_ASSERT_NOW(a_active_has_pixels, aclk, aresetn, line_active_reg, left_reg != '0, "active line with no pixels left")
    `LRPW_ASSERT_NEXT(a_last_ends_line, aclk, aresetn, adv && emit && is_last, !line_active_reg && m_tvalid && m_tlast, "last pixel did not end the line")
    `LRPW_ASSERT_NEXT(a_start_arms_line, aclk, aresetn, adv && in_op_reg == lrpw_pkg::OP_START, line_active_reg && err_reg == '0, "start word did not arm the line")

endmodule

FILE: tb/line_rasterizer_pixel_writer_tb.sv
module line_rasterizer_pixel_writer_tb;

    localparam int ALL_PIXELS   = 1 << 30;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_WORDS  = 175;
    localparam int SETTLE_TICKS = 4;

    typedef struct {
        logic [31:0] address;
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } pixel_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    // register shadow
    logic [lrpw_pkg::BPP_W-1:0]   reg_bpp;
    logic [lrpw_pkg::PITCH_W-1:0] reg_pitch;
    logic [lrpw_pkg::LIMIT_W-1:0] reg_max_x;
    logic [lrpw_pkg::LIMIT_W-1:0] reg_max_y;
    logic                         reg_big_endian;

    // rasterizer shadow
    logic        pen_active;
    logic [31:0] pen_offset;
    logic [13:0] pen_error;
    logic [12:0] pen_remaining;
    logic [11:0] pen_major;
    logic [11:0] pen_minor;
    logic        pen_x_major;
    logic        pen_x_back;
    logic        pen_y_back;
    logic [31:0] pen_color;

    pixel_write_t        pending_pixels[$];
    pixel_write_t        want_pixel;
    lrpw_pkg::out_word_t got_word;
    int                  error_count = 0;
    int                  words_sent = 0;
    int                  src_idle_pct = 0;
    int                  sink_stall_pct = 0;

    line_rasterizer_pixel_writer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [11:0] clamp_coord(logic [15:0] raw, logic [11:0] limit);
        if (raw[15]) return '0;
        if (raw > {4'h0, limit}) return limit;
        return raw[11:0];
    endfunction

    function automatic logic [31:0] advance(logic [31:0] off, logic [31:0] amount, logic back);
        return back ? off - amount : off + amount;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    task automatic predict_word(logic op, lrpw_pkg::in_word_t w);
        logic [2:0]   bpp;
        logic [11:0]  x1, y1, x2, y2, dx, dy;
        logic [31:0]  c;
        pixel_write_t px;
        bpp = (reg_bpp == lrpw_pkg::BPP_NONE) ? lrpw_pkg::BPP_ONE :
              (reg_bpp > lrpw_pkg::BPP_FOUR) ? lrpw_pkg::BPP_FOUR : reg_bpp;
        if (op == lrpw_pkg::OP_START) begin
            x1 = clamp_coord(w.start_x, reg_max_x);
            y1 = clamp_coord(w.start_y, reg_max_y);
            x2 = clamp_coord(w.end_x, reg_max_x);
            y2 = clamp_coord(w.end_y, reg_max_y);
            pen_x_back = x2 < x1;
            pen_y_back = y2 < y1;
            dx = pen_x_back ? x1 - x2 : x2 - x1;
            dy = pen_y_back ? y1 - y2 : y2 - y1;
            pen_x_major = dx > dy;
            pen_major = pen_x_major ? dx : dy;
            pen_minor = pen_x_major ? dy : dx;
            pen_offset = 32'(y1) * 32'(reg_pitch) + 32'(x1) * 32'(bpp);
            pen_error = '0;
            pen_remaining = {1'b0, pen_major} + 13'd1;
            pen_color = w.line_color;
            pen_active = 1'b1;
        end else if (pen_active) begin
            c = pen_color;
            px.address = pen_offset;
            case (bpp)
                lrpw_pkg::BPP_ONE: px.data = {24'h0, c[7:0]};
                lrpw_pkg::BPP_TWO: px.data = {16'h0, c[15:0]};
                lrpw_pkg::BPP_THREE: begin
                    px.data = reg_big_endian ? {8'h0, c[7:0], c[15:8], c[23:16]}
                                             : {8'h0, c[23:0]};
                end
                default: px.data = c;
            endcase
            px.count = bpp;
            px.last = (pen_remaining <= 13'd1);
            pending_pixels.push_back(px);
            if (pen_x_major) pen_offset = advance(pen_offset, 32'(bpp), pen_x_back);
            else pen_offset = advance(pen_offset, 32'(reg_pitch), pen_y_back);
            pen_error = pen_error + 14'(pen_minor);
            if (pen_error > 14'(pen_major)) begin
                pen_error = pen_error - 14'(pen_major);
                if (pen_x_major) pen_offset = advance(pen_offset, 32'(reg_pitch), pen_y_back);
                else pen_offset = advance(pen_offset, 32'(bpp), pen_x_back);
            end
            if (pen_remaining <= 13'd1) begin
                pen_remaining = '0;
                pen_active = 1'b0;
            end else begin
                pen_remaining = pen_remaining - 13'd1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word = m_tdata;
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel write, address", got_word.pixel_address, '0);
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (got_word.pixel_address !== want_pixel.address)
                    report_mismatch("pixel_address", got_word.pixel_address, want_pixel.address);
                if (got_word.pixel_data !== want_pixel.data)
                    report_mismatch("pixel_data", got_word.pixel_data, want_pixel.data);
                if (got_word.byte_count !== want_pixel.count)
                    report_mismatch("byte_count", 32'(got_word.byte_count), 32'(want_pixel.count));
                if (m_tlast !== want_pixel.last)
                    report_mismatch("last_pixel", 32'(m_tlast), 32'(want_pixel.last));
            end
        end
    end

    task automatic send_word(logic op, int sx, int sy, int ex, int ey, logic [31:0] color);
        lrpw_pkg::in_word_t w;
        w.start_x = sx[15:0];
        w.start_y = sy[15:0];
        w.end_x = ex[15:0];
        w.end_y = ey[15:0];
        w.line_color = color;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= w;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_word(op, w);
        words_sent++;
    endtask

    // fields of a step word are don't-care, so fill them with noise
    task automatic step_pen();
        send_word(lrpw_pkg::OP_STEP, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
    endtask

    task automatic draw_line(int x1, int y1, int x2, int y2, logic [31:0] color, int max_steps);
        int n;
        send_word(lrpw_pkg::OP_START, x1, y1, x2, y2, color);
        n = 0;
        while (pen_active && n < max_steps) begin
            step_pen();
            n++;
        end
    endtask

    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            lrpw_pkg::REG_BPP:        reg_bpp = value[2:0];
            lrpw_pkg::REG_ROW_PITCH:  reg_pitch = value;
            lrpw_pkg::REG_MAX_X:      reg_max_x = value[11:0];
            lrpw_pkg::REG_MAX_Y:      reg_max_y = value[11:0];
            lrpw_pkg::REG_BIG_ENDIAN: reg_big_endian = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits of the data word get noise half the time
    task automatic configure(logic [2:0] bpp, logic [15:0] pitch, logic [11:0] mx,
                             logic [11:0] my, logic be);
        logic [15:0] junk;
        wait_for_idle();
        junk = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
        write_reg(lrpw_pkg::REG_BPP, {junk[15:3], bpp});
        write_reg(lrpw_pkg::REG_ROW_PITCH, pitch);
        write_reg(lrpw_pkg::REG_MAX_X, {junk[15:12], mx});
        write_reg(lrpw_pkg::REG_MAX_Y, {junk[11:8], my});
        write_reg(lrpw_pkg::REG_BIG_ENDIAN, {junk[15:1], be});
    endtask

    task automatic test_reset_defaults();
        step_pen();
        draw_line(0, 0, 2, 1, 32'hA1B2C3D4, ALL_PIXELS);
        step_pen();
    endtask

    task automatic test_clamping();
        draw_line(-32768, 32767, 32767, -32768, 32'h5A5AA5A5, 2);
        configure(lrpw_pkg::BPP_THREE, 16'd1, 12'd0, 12'd0, 1'b1);
        draw_line(-5, 9000, 100, -100, 32'h00112233, ALL_PIXELS);
    endtask

    task automatic test_axes();
        configure(lrpw_pkg::BPP_TWO, 16'hffff, 12'd4095, 12'd4095, 1'b0);
        draw_line(10, 10, 12, 12, 32'hFFFFFFFF, ALL_PIXELS);
        // restart before the line ends
        draw_line(4095, 4095, 4000, 4094, 32'h0F0F0F0F, 3);
        draw_line(100, 200, 99, 203, 32'hF0F0F0F0, ALL_PIXELS);
    endtask

    task automatic test_config_mid_line();
        draw_line(5, 5, 9, 7, 32'hDEADBEEF, 1);
        wait_for_idle();
        write_reg(lrpw_pkg::REG_BPP, 16'(lrpw_pkg::BPP_THREE));
        write_reg(lrpw_pkg::REG_ROW_PITCH, 16'd300);
        write_reg(lrpw_pkg::REG_BIG_ENDIAN, 16'd1);
        step_pen();
        step_pen();
    endtask

    task automatic random_burst();
        int r, x1, y1, x2, y2;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            x1 = $urandom_range(0, reg_max_x);
            y1 = $urandom_range(0, reg_max_y);
            x2 = x1 + $urandom_range(0, 24) - 12;
            y2 = y1 + $urandom_range(0, 24) - 12;
            if ($urandom_range(0, 9) == 0)
                draw_line(x1, y1, x2, y2, $urandom, $urandom_range(0, 12));
            else
                draw_line(x1, y1, x2, y2, $urandom, ALL_PIXELS);
        end else if (r < 90) begin
            draw_line($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom, $urandom_range(0, 5));
        end else begin
            step_pen();
        end
    endtask

    task automatic test_random();
        int first;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: configure(lrpw_pkg::RST_BPP, lrpw_pkg::RST_ROW_PITCH, lrpw_pkg::RST_MAX_X,
                             lrpw_pkg::RST_MAX_Y, 1'b0);
                1: configure(lrpw_pkg::BPP_ONE, 16'd1, 12'd4095, 12'd4095, 1'b0);
                2: configure(lrpw_pkg::BPP_TWO, 16'hffff, 12'd4095, 12'd4095, 1'b1);
                3: configure(lrpw_pkg::BPP_THREE, 16'($urandom), 12'($urandom), 12'($urandom),
                             1'b0);
                4: configure(lrpw_pkg::BPP_THREE, 16'($urandom), 12'd319, 12'd239, 1'b1);
                5: configure(lrpw_pkg::BPP_NONE, 16'($urandom), 12'($urandom), 12'($urandom),
                             1'($urandom));
                6: configure(3'($urandom_range(5, 7)), 16'($urandom), 12'($urandom),
                             12'($urandom), 1'($urandom));
                7: configure(3'($urandom), 16'($urandom), 12'($urandom), 12'($urandom),
                             1'($urandom));
                8: configure(lrpw_pkg::BPP_FOUR, 16'hffff, 12'd0, 12'd4095, 1'b0);
                default: configure(lrpw_pkg::BPP_ONE, 16'($urandom), 12'd4095, 12'd0, 1'b1);
            endcase
            case (phase % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 46;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 46;
                end
                default: begin
                    src_idle_pct = 15;
                    sink_stall_pct = 15;
                end
            endcase
            first = words_sent;
            while (words_sent - first < PHASE_WORDS) random_burst();
        end
    endtask

    initial begin
        reg_bpp = lrpw_pkg::RST_BPP;
        reg_pitch = lrpw_pkg::RST_ROW_PITCH;
        reg_max_x = lrpw_pkg::RST_MAX_X;
        reg_max_y = lrpw_pkg::RST_MAX_Y;
        reg_big_endian = 1'b0;
        pen_active = 1'b0;
        pen_offset = '0;
        pen_error = '0;
        pen_remaining = '0;
        pen_major = '0;
        pen_minor = '0;
        pen_x_major = 1'b0;
        pen_x_back = 1'b0;
        pen_y_back = 1'b0;
        pen_color = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_clamping();
        test_axes();
        test_config_mid_line();
        test_random();

        wait_for_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lrpw_pkg.sv
hw/rtl/line_rasterizer_pixel_writer.sv
tb/line_rasterizer_pixel_writer_tb.sv
